// ----- rtl/rssi_median_signal_meter_unit_assert.svh -----
// assertion helpers for the signal meter, compiled out when SYNTH is set
`ifndef RSSI_MEDIAN_SIGNAL_METER_UNIT_ASSERT_SVH
`define RSSI_MEDIAN_SIGNAL_METER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RSSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RSSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSSI_ASSERT_NOW(lbl, ante, cons, msg)
`define RSSI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/rssi_pkg.sv -----
package rssi_pkg;

  // register indexes
  localparam logic REG_IDLE = 1'b0;
  localparam logic REG_FULL = 1'b1;

  localparam logic [7:0] IDLE_RESET = 8'(110 >> 2);
  localparam logic [7:0] FULL_RESET = 8'(340 >> 2);
  localparam logic [6:0] PCT_MAX    = 7'd100;
  localparam int         DIV_STEPS  = 7;

  typedef struct packed {
    logic       func;
    logic [7:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic [7:0] level;
    logic [6:0] signal_percent;
  } out_word_t;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_EVAL   = 1'b1
  } func_t;

  typedef logic [2:0] pc_t;

  localparam pc_t PC_IDLE   = 3'd0;
  localparam pc_t PC_SORT   = 3'd1;
  localparam pc_t PC_MID    = 3'd2;
  localparam pc_t PC_SETUP  = 3'd3;
  localparam pc_t PC_DIV    = 3'd4;
  localparam pc_t PC_FINISH = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_IDLE,
    OP_SORT,
    OP_MID,
    OP_SETUP,
    OP_DIV,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,   // go to target
    COND_START,    // go to target when an evaluate word is taken
    COND_LOOP,     // repeat until the step counter ends, then target
    COND_DECIDED,  // target if percent settled without dividing, else next
    COND_OUT_FREE  // go to target once the result register is free
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } cw_t;

  localparam cw_t UCODE [8] = '{
    '{op: OP_IDLE,   cond: COND_START,    target: PC_SORT},
    '{op: OP_SORT,   cond: COND_LOOP,     target: PC_MID},
    '{op: OP_MID,    cond: COND_ALWAYS,   target: PC_SETUP},
    '{op: OP_SETUP,  cond: COND_DECIDED,  target: PC_FINISH},
    '{op: OP_DIV,    cond: COND_LOOP,     target: PC_FINISH},
    '{op: OP_FINISH, cond: COND_OUT_FREE, target: PC_IDLE},
    '{op: OP_NOP,    cond: COND_ALWAYS,   target: PC_IDLE},
    '{op: OP_NOP,    cond: COND_ALWAYS,   target: PC_IDLE}
  };

endpackage

// ----- rtl/rssi_median_signal_meter_unit.sv -----
// signal meter: median of a ring of converter samples, shown as a percent
//
// in channel (in_valid/in_ready/in_word): func 0 stores adc_sample in the
// ring and advances the write index, func 1 evaluates the ring. a sample
// word gives no result. an evaluate word starts a small
// microcoded sequencer: SAMPLE_COUNT odd-even compare-exchange passes over
// the ring, a step for the middle average, a step for the percent setup,
// 7 restoring division steps when the percent needs them, one finish step.
// no new in word is taken until the finish step has posted the out word.
// out channel (out_valid/out_ready/out_word): one word per evaluation with
// level and signal_percent, held in an output register. while that word
// waits, sample words and a following evaluation are still taken; only the
// finish step of the next evaluation waits for the register to drain.
// the finish step clears the ring and the write index.
// cfg port: cfg_we writes cfg_wdata to idle (index 0) or full (index 1).
// reset (synchronous, rst_n low) clears ring, index, sequencer and output
// valid, and loads idle 27 and full 85.
`include "rssi_median_signal_meter_unit_assert.svh"

module rssi_median_signal_meter_unit
  import rssi_pkg::*;
#(
  parameter int SAMPLE_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(SAMPLE_COUNT);
  localparam int CNT_W  = ($clog2(SAMPLE_COUNT) > 3) ? $clog2(SAMPLE_COUNT) : 3;
  localparam int MID_LO = (SAMPLE_COUNT - 1) / 2;
  localparam int MID_HI = SAMPLE_COUNT / 2;

  // configuration
  logic [7:0] idle_r, full_r;

  // sample ring, sorted in place during evaluation
  logic [7:0]       ring_r   [SAMPLE_COUNT];
  logic [7:0]       ring_nxt [SAMPLE_COUNT];
  logic [IDX_W-1:0] widx_r, widx_nxt;

  // sequencer
  pc_t        pc_r, pc_nxt;
  cw_t        cw;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic       cnt_done;

  // datapath
  logic [7:0] level_r, level_nxt;
  logic [6:0] q_r, q_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] den_r, den_nxt;
  logic [6:0] numlo_r, numlo_nxt;
  logic       decided;

  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  logic       in_acc;
  logic       out_free;

  // setup and divider helpers
  logic [8:0]  mid_sum;
  logic [7:0]  a_w, diff_w;
  logic [14:0] num_w;
  logic [8:0]  trial_w;

  assign cw       = UCODE[pc_r];
  assign in_ready = (cw.op == OP_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign cnt_done = (cw.op == OP_SORT) ? (cnt_r == CNT_W'(SAMPLE_COUNT - 1))
                                       : (cnt_r == CNT_W'(DIV_STEPS - 1));

  assign mid_sum = {1'b0, ring_r[MID_LO]} + {1'b0, ring_r[MID_HI]};
  assign a_w     = (level_r < idle_r) ? idle_r : level_r;
  assign diff_w  = a_w - idle_r;
  assign num_w   = 15'(diff_w) * 15'(PCT_MAX);
  assign trial_w = {rem_r, numlo_r[6]};

  // settled without a division: zero level, degenerate range or saturation
  assign decided = (level_r == 8'd0) || (full_r <= idle_r) || (a_w >= full_r);

  always_comb begin
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    widx_nxt      = widx_r;
    ring_nxt      = ring_r;
    level_nxt     = level_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    numlo_nxt     = numlo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;

    case (cw.op)
      OP_IDLE: begin
        if (in_acc && (in_word.func == FUNC_SAMPLE)) begin
          ring_nxt[widx_r] = in_word.adc_sample;
          widx_nxt = (widx_r == IDX_W'(SAMPLE_COUNT - 1)) ? '0 : widx_r + 1'b1;
        end
      end
      OP_SORT: begin
        // odd-even transposition pass, larger value to the lower index
        for (int j = 0; j < SAMPLE_COUNT - 1; j++) begin
          if ((j % 2) == int'(cnt_r[0]) && (ring_r[j] < ring_r[j+1])) begin
            ring_nxt[j]   = ring_r[j+1];
            ring_nxt[j+1] = ring_r[j];
          end
        end
      end
      OP_MID: begin
        level_nxt = mid_sum[8:1];
      end
      OP_SETUP: begin
        if (level_r == 8'd0) begin
          q_nxt = '0;
        end else if (full_r <= idle_r) begin
          q_nxt = (level_r > idle_r) ? PCT_MAX : '0;
        end else if (a_w >= full_r) begin
          q_nxt = PCT_MAX;
        end else begin
          // quotient stays below 100, so the top bits are already below den
          q_nxt     = '0;
          rem_nxt   = num_w[14:7];
          numlo_nxt = num_w[6:0];
          den_nxt   = full_r - idle_r;
        end
      end
      OP_DIV: begin
        if (trial_w >= {1'b0, den_r}) begin
          rem_nxt = 8'(trial_w - {1'b0, den_r});
          q_nxt   = {q_r[5:0], 1'b1};
        end else begin
          rem_nxt = trial_w[7:0];
          q_nxt   = {q_r[5:0], 1'b0};
        end
        numlo_nxt = {numlo_r[5:0], 1'b0};
      end
      OP_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{level: level_r, signal_percent: q_r};
          for (int k = 0; k < SAMPLE_COUNT; k++) begin
            ring_nxt[k] = '0;
          end
          widx_nxt = '0;
        end
      end
      default: begin
      end
    endcase

    // step counter runs only inside loop steps
    if (cw.cond == COND_LOOP) begin
      cnt_nxt = cnt_done ? '0 : cnt_r + 1'b1;
    end

    case (cw.cond)
      COND_ALWAYS:   pc_nxt = cw.target;
      COND_START:    if (in_acc && (in_word.func == FUNC_EVAL)) pc_nxt = cw.target;
      COND_LOOP:     if (cnt_done) pc_nxt = cw.target;
      COND_DECIDED:  pc_nxt = decided ? cw.target : pc_r + 1'b1;
      COND_OUT_FREE: if (out_free) pc_nxt = cw.target;
      default:       pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      cnt_r       <= '0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
      idle_r      <= IDLE_RESET;
      full_r      <= FULL_RESET;
      for (int k = 0; k < SAMPLE_COUNT; k++) begin
        ring_r[k] <= '0;
      end
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
      ring_r      <= ring_nxt;
      if (cfg_we && (cfg_index == REG_IDLE)) begin
        idle_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == REG_FULL)) begin
        full_r <= cfg_wdata;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    level_r    <= level_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    numlo_r    <= numlo_nxt;
    out_word_r <= out_word_nxt;
  end

  `RSSI_ASSERT_NOW(a_pct_range, out_valid, out_word.signal_percent <= PCT_MAX, "percent above 100")
  `RSSI_ASSERT_NOW(a_div_rem, pc_r == PC_DIV, rem_r < den_r, "divider remainder not below divisor")
  `RSSI_ASSERT_NEXT(a_clear, (pc_r == PC_FINISH) && out_free, (widx_r == '0) && out_valid, "finish did not clear index or post result")

endmodule
